>>> rtl/core/lcd_nibble_expander_writer_top_macros.svh
// Assertion macros for the LCD nibble expander writer.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef LCD_NIBBLE_EXPANDER_WRITER_TOP_MACROS_SVH
`define LCD_NIBBLE_EXPANDER_WRITER_TOP_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define LCDNX_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define LCDNX_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> rtl/core/lcdnx_pkg.sv
// Shared types and constants for the LCD nibble expander writer.
// No dependencies; used by lcdnx_req_decode and the top level.
package lcdnx_pkg;

    typedef enum logic [2:0] {
        KIND_DATA      = 3'd0,
        KIND_COMMAND   = 3'd1,
        KIND_INIT      = 3'd2,
        KIND_CURSOR    = 3'd3,
        KIND_BACKLIGHT = 3'd4
    } t_kind;

    // How many expander bytes a request expands to
    typedef enum logic [1:0] {
        MODE_FULL   = 2'd0,  // two nibbles, six bytes
        MODE_NIBBLE = 2'd1,  // high nibble only, three bytes
        MODE_SINGLE = 2'd2   // one byte, no enable pulse
    } t_mode;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       rs;
        t_mode      mode;
    } t_req;

    localparam logic [7:0] CMD_DDRAM = 8'h80;
    localparam logic [7:0] NIB_MASK  = 8'hf0;

    localparam int REG_BACKLIGHT  = 0;
    localparam int REG_LINE_COUNT = 1;

    localparam logic [2:0] LINE_COUNT_RESET = 3'd2;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        unique case (row)
            2'd0: base = 8'h00;
            2'd1: base = 8'h40;
            2'd2: base = 8'h14;
            2'd3: base = 8'h54;
            default: base = 8'h00;
        endcase
        return base;
    endfunction

endpackage

>>> rtl/core/lcdnx_req_decode.sv
// Request decoder: turns one LCD request into the byte to send and its expansion mode.
// Depends on lcdnx_pkg.
module lcdnx_req_decode (
    input  logic [2:0]      i_kind,
    input  logic [7:0]      i_value,
    input  logic [5:0]      i_column,
    input  logic [1:0]      i_row,
    input  logic [2:0]      i_line_count,
    output lcdnx_pkg::t_req o_req
);

    logic [2:0] lines;
    logic [1:0] row_c;
    logic [7:0] addr;

    // Clamp the line count to 1..4, then the row to the last line
    always_comb begin
        priority if (i_line_count == 3'd0) begin
            lines = 3'd1;
        end else if (i_line_count > 3'd4) begin
            lines = 3'd4;
        end else begin
            lines = i_line_count;
        end
        if ({1'b0, i_row} >= lines) begin
            row_c = 2'(lines - 3'd1);
        end else begin
            row_c = i_row;
        end
        addr = {2'b00, i_column} + lcdnx_pkg::row_base(row_c);
    end

    always_comb begin
        o_req.valid = 1'b1;
        o_req.data  = i_value;
        o_req.rs    = 1'b0;
        o_req.mode  = lcdnx_pkg::MODE_FULL;
        unique case (lcdnx_pkg::t_kind'(i_kind))
            lcdnx_pkg::KIND_DATA: begin
                o_req.rs = 1'b1;
            end
            lcdnx_pkg::KIND_COMMAND: begin
                o_req.rs = 1'b0;
            end
            lcdnx_pkg::KIND_INIT: begin
                o_req.data = i_value & lcdnx_pkg::NIB_MASK;
                o_req.mode = lcdnx_pkg::MODE_NIBBLE;
            end
            lcdnx_pkg::KIND_CURSOR: begin
                o_req.data = lcdnx_pkg::CMD_DDRAM | addr;
            end
            lcdnx_pkg::KIND_BACKLIGHT: begin
                o_req.data = 8'h00;
                o_req.mode = lcdnx_pkg::MODE_SINGLE;
            end
            default: begin
                // undefined kind: consume the request, emit nothing
                o_req.valid = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/lcd_nibble_expander_writer_top.sv
// Top level of the LCD nibble expander writer: request stream in, expander byte stream out.
// Depends on lcdnx_pkg, lcdnx_req_decode and lcd_nibble_expander_writer_top_macros.svh.

// A request (tuser = kind; tdata = value, column, row) becomes the bytes to write to an
// 8-bit port expander driving a character LCD in 4-bit mode, one byte per transaction on
// the output stream. Data, command and set-cursor requests give six bytes, high nibble
// first (nibble, nibble with enable, nibble without enable); an init nibble gives three
// bytes, a backlight write one byte, and an undefined kind none. tlast marks the final
// byte of each request. The output stream carries one byte per cycle while the receiver
// accepts; an undefined kind is consumed and leaves the block free. The next request is
// taken in the cycle its predecessor's last byte moves to the output register, so
// requests follow without gaps. The first byte of a request passes through the request
// register and then the output register before it is offered on the output. Configuration
// writes (index 0 backlight, index 1 line count) take effect at once and belong to idle
// periods.
module lcd_nibble_expander_writer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] value, [13:8] column, [15:14] row
    input  logic [2:0]  i_s_tuser,   // [2:0] kind
    // expander byte stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] expander_byte
    output logic        o_m_tlast,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_wdata
);

    // configuration registers
    logic       r_backlight;
    logic [2:0] r_line_count;

    // request being expanded
    logic              r_a_valid;
    logic [7:0]        r_a_data;
    logic              r_a_rs;
    lcdnx_pkg::t_mode  r_a_mode;
    logic              r_a_hi;    // high nibble in progress
    logic [1:0]        r_a_sub;   // 0 plain, 1 enable high, 2 enable low
    logic              n_a_valid;
    logic              n_a_hi;
    logic [1:0]        n_a_sub;

    // output register
    logic       r_o_valid;
    logic [7:0] r_o_byte;
    logic       r_o_last;

    lcdnx_pkg::t_req dec;
    logic            s_acc;
    logic            out_adv;
    logic            a_emit;
    logic            a_last;
    logic [3:0]      nib;
    logic            en;
    logic [7:0]      emit_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight  <= 1'b0;
            r_line_count <= lcdnx_pkg::LINE_COUNT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'(lcdnx_pkg::REG_BACKLIGHT)) begin
                r_backlight <= i_cfg_wdata[0];
            end else begin
                r_line_count <= i_cfg_wdata;
            end
        end
    end

    lcdnx_req_decode u_decode (
        .i_kind       (i_s_tuser),
        .i_value      (i_s_tdata[7:0]),
        .i_column     (i_s_tdata[13:8]),
        .i_row        (i_s_tdata[15:14]),
        .i_line_count (r_line_count),
        .o_req        (dec)
    );

    // Advance the output register whenever it is empty or being taken
    assign out_adv = !r_o_valid || i_m_tready;
    assign a_emit  = r_a_valid && out_adv;

    always_comb begin
        if (r_a_mode == lcdnx_pkg::MODE_FULL && !r_a_hi) begin
            nib = r_a_data[3:0];
        end else begin
            nib = r_a_data[7:4];
        end
        en = (r_a_sub == 2'd1) && (r_a_mode != lcdnx_pkg::MODE_SINGLE);
        emit_byte = {nib, r_backlight, en, 1'b0, r_a_rs};
        unique case (r_a_mode)
            lcdnx_pkg::MODE_FULL:   a_last = (r_a_sub == 2'd2) && !r_a_hi;
            lcdnx_pkg::MODE_NIBBLE: a_last = (r_a_sub == 2'd2);
            lcdnx_pkg::MODE_SINGLE: a_last = 1'b1;
            default:                a_last = 1'b1;
        endcase
    end

    // Take a new request when nothing is in flight or the last byte leaves now
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = !r_a_valid || (out_adv && a_last);

    always_comb begin
        n_a_valid = r_a_valid;
        n_a_hi    = r_a_hi;
        n_a_sub   = r_a_sub;
        if (s_acc) begin
            n_a_valid = dec.valid;
            n_a_hi    = 1'b1;
            n_a_sub   = 2'd0;
        end else if (a_emit) begin
            if (a_last) begin
                n_a_valid = 1'b0;
            end
            if (r_a_sub == 2'd2) begin
                // move on to the low nibble
                n_a_sub = 2'd0;
                n_a_hi  = 1'b0;
            end else begin
                n_a_sub = r_a_sub + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_hi    <= 1'b1;
            r_a_sub   <= 2'd0;
        end else begin
            r_a_valid <= n_a_valid;
            r_a_hi    <= n_a_hi;
            r_a_sub   <= n_a_sub;
        end
    end

    // Payload of the request: load on every transaction, hold otherwise
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_a_data <= dec.data;
            r_a_rs   <= dec.rs;
            r_a_mode <= dec.mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_adv) begin
            r_o_valid <= a_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_emit) begin
            r_o_byte <= emit_byte;
            r_o_last <= a_last;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_byte;
    assign o_m_tlast  = r_o_last;

`include "lcd_nibble_expander_writer_top_macros.svh"

    // The sub-step counter only runs through plain, enable high, enable low
    `LCDNX_ASSERT_ALWAYS(a_sub_range, !r_a_valid || r_a_sub != 2'd3, "sub-step out of range")

    // The final byte of a request never leaves the enable line high
    `LCDNX_ASSERT_ALWAYS(last_enable_low, !(o_m_tvalid && o_m_tlast) || !o_m_tdata[2],
        "last byte with enable high")

    // After a request's last byte the expander is empty or at the start of a new request
    `LCDNX_ASSERT_NEXT(restart_clean, a_emit && a_last,
        !r_a_valid || (r_a_sub == 2'd0 && r_a_hi), "request did not restart cleanly")

endmodule

>>> tb/lcd_nibble_expander_writer_top_tb.sv
// Self-checking testbench for lcd_nibble_expander_writer_top: request stream in,
// expander byte stream out, checked against an in-bench expansion of each request.
// Depends on lcdnx_pkg and the RTL of the top level.
module lcd_nibble_expander_writer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Expander bit positions
    localparam logic [7:0] BIT_RS = 8'h01;
    localparam logic [7:0] BIT_EN = 8'h04;
    localparam logic [7:0] BIT_BL = 8'h08;

    // DDRAM start address of each display line
    localparam logic [7:0] LINE_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    // Highest code the kind field can carry; codes above KIND_BACKLIGHT are undefined
    localparam logic [2:0] KIND_TOP = 3'd7;

    localparam int MAX_GAP       = 16;
    localparam int HOLD_OFF      = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] value;
        logic [5:0] column;
        logic [1:0] row;
    } t_lcd_req;

    typedef struct {
        logic [7:0] exp_byte;
        logic       exp_last;
    } t_exp_byte;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata   = '0;
    logic [2:0]  i_s_tuser   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [2:0]  i_cfg_wdata = '0;

    lcd_nibble_expander_writer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copies of the two registers, updated as they are written
    logic       backlight_shadow = 1'b0;
    logic [2:0] lines_shadow     = lcdnx_pkg::LINE_COUNT_RESET;

    t_lcd_req  requests_to_send [$];
    t_exp_byte bytes_due [$];

    // Per-phase knobs set by the stimulus sequence
    logic tx_idle_on     = 1'b1;
    logic rx_idle_on     = 1'b1;
    logic pressure_phase = 1'b0;

    logic req_taken  = 1'b0;  // request transaction at the last rising edge
    logic byte_taken = 1'b0;  // output transaction at the last rising edge

    int tx_gap     = 0;
    int rx_stall   = 0;
    int hold_cnt   = 0;
    logic hold_done = 1'b0;
    int mismatches = 0;
    int cycle_cnt  = 0;

    // ------------------------------------------------------------------
    // Expected expander bytes for one accepted request
    // ------------------------------------------------------------------
    function automatic void push_expander(input logic [7:0] b);
        t_exp_byte e;
        e.exp_byte = b | (backlight_shadow ? BIT_BL : 8'h00);
        e.exp_last = 1'b0;
        bytes_due.push_back(e);
    endfunction

    // One nibble strobe: set up, enable high, enable low
    function automatic void push_nibble(input logic [7:0] nib_rs);
        push_expander(nib_rs);
        push_expander(nib_rs | BIT_EN);
        push_expander(nib_rs & ~BIT_EN);
    endfunction

    function automatic void push_full_byte(input logic [7:0] v, input logic [7:0] rs);
        push_nibble((v & lcdnx_pkg::NIB_MASK) | rs);
        push_nibble(((v << 4) & lcdnx_pkg::NIB_MASK) | rs);
    endfunction

    function automatic void expand_request(input t_lcd_req r);
        int         prior_cnt;
        logic [2:0] lines;
        logic [1:0] line_sel;
        logic [7:0] addr;
        prior_cnt = bytes_due.size();
        case (r.kind)
            lcdnx_pkg::KIND_DATA:      push_full_byte(r.value, BIT_RS);
            lcdnx_pkg::KIND_COMMAND:   push_full_byte(r.value, 8'h00);
            lcdnx_pkg::KIND_INIT:      push_nibble(r.value & lcdnx_pkg::NIB_MASK);
            lcdnx_pkg::KIND_CURSOR: begin
                // Clamp the line count into 1..4, then the row onto the last line
                lines = lines_shadow;
                if (lines == 3'd0) lines = 3'd1;
                if (lines > 3'd4) lines = 3'd4;
                line_sel = ({1'b0, r.row} >= lines) ? 2'(lines - 3'd1) : r.row;
                addr = 8'(r.column) + LINE_OFFSET[line_sel];
                push_full_byte(lcdnx_pkg::CMD_DDRAM | addr, 8'h00);
            end
            lcdnx_pkg::KIND_BACKLIGHT: push_expander(8'h00);
            default: ;  // undefined kinds expand to nothing
        endcase
        if (bytes_due.size() > prior_cnt)
            bytes_due[bytes_due.size() - 1].exp_last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: change at the falling edge, hold until accepted
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : req_driver
        t_lcd_req r;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !req_taken) begin
            // hold the offered request
        end else if (tx_gap > 0) begin
            tx_gap     <= tx_gap - 1;
            i_s_tvalid <= 1'b0;
        end else if (requests_to_send.size() != 0) begin
            r          = requests_to_send.pop_front();
            i_s_tdata  <= {r.row, r.column, r.value};
            i_s_tuser  <= r.kind;
            i_s_tvalid <= 1'b1;
            // gap to leave after this request is taken
            tx_gap     <= tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Byte receiver: random stalls per byte, one long hold-off when asked
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : byte_receiver
        int s;
        s = 0;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt   <= hold_cnt - 1;
            i_m_tready <= 1'b0;
        end else if (pressure_phase && !hold_done) begin
            // close the output for a long stretch so the block backs up
            hold_done  <= 1'b1;
            hold_cnt   <= HOLD_OFF;
            i_m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall   <= rx_stall - 1;
            i_m_tready <= 1'b0;
        end else begin
            if (byte_taken && rx_idle_on)
                s = $urandom_range(0, MAX_GAP);
            if (s > 0) begin
                rx_stall   <= s - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on request transactions, check output transactions
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_lcd_req  r;
        t_exp_byte e;
        req_taken  <= i_rst_n && i_s_tvalid && o_s_tready;
        byte_taken <= i_rst_n && o_m_tvalid && i_m_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            r.kind   = i_s_tuser;
            r.value  = i_s_tdata[7:0];
            r.column = i_s_tdata[13:8];
            r.row    = i_s_tdata[15:14];
            expand_request(r);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (bytes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected byte %02h last %0b", $realtime, o_m_tdata,
                             o_m_tlast);
            end else begin
                e = bytes_due.pop_front();
                if (o_m_tdata !== e.exp_byte || o_m_tlast !== e.exp_last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: byte exp %02h got %02h, last exp %0b got %0b",
                                 $realtime, e.exp_byte, o_m_tdata, e.exp_last, o_m_tlast);
                end
            end
        end
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    task automatic write_reg(input int idx, input logic [2:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx[0];
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == lcdnx_pkg::REG_BACKLIGHT)
            backlight_shadow = data[0];
        else
            lines_shadow = data;
    endtask

    task automatic add_req(input logic [2:0] kind, input logic [7:0] value,
                           input logic [5:0] column, input logic [1:0] row);
        t_lcd_req r;
        r.kind   = kind;
        r.value  = value;
        r.column = column;
        r.row    = row;
        requests_to_send.push_back(r);
    endtask

    // Mostly defined kinds with random fields; a few undefined codes as noise
    task automatic add_random(input int n);
        logic [2:0] k;
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                k = 3'($urandom_range(lcdnx_pkg::KIND_BACKLIGHT + 1, KIND_TOP));
            else
                k = 3'($urandom_range(lcdnx_pkg::KIND_DATA, lcdnx_pkg::KIND_BACKLIGHT));
            add_req(k, 8'($urandom), 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)));
        end
    endtask

    // Wait for all requests to go out and all bytes to come back, then let an
    // undefined kind still in flight clear the pipeline
    task automatic drain();
        while (requests_to_send.size() != 0 || i_s_tvalid || bytes_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: backlight off, two lines
        add_req(lcdnx_pkg::KIND_DATA,      8'h00, 6'd0,  2'd0);
        add_req(lcdnx_pkg::KIND_DATA,      8'hff, 6'd63, 2'd3);
        add_req(lcdnx_pkg::KIND_DATA,      8'ha5, 6'd21, 2'd2);
        add_req(lcdnx_pkg::KIND_COMMAND,   8'h5a, 6'd42, 2'd1);
        add_req(lcdnx_pkg::KIND_COMMAND,   8'hff, 6'd0,  2'd0);
        add_req(lcdnx_pkg::KIND_INIT,      8'h3f, 6'd0,  2'd0);  // low bits must be dropped
        add_req(lcdnx_pkg::KIND_INIT,      8'h20, 6'd63, 2'd3);
        add_req(lcdnx_pkg::KIND_CURSOR,    8'h00, 6'd0,  2'd0);
        add_req(lcdnx_pkg::KIND_CURSOR,    8'hff, 6'd39, 2'd3);  // row beyond the panel
        add_req(lcdnx_pkg::KIND_CURSOR,    8'h00, 6'd63, 2'd1);
        add_req(lcdnx_pkg::KIND_BACKLIGHT, 8'hff, 6'd63, 2'd3);  // fields ignored
        add_req(3'd5,                      8'h12, 6'd5,  2'd1);
        add_req(3'd6,                      8'hff, 6'd63, 2'd3);
        add_req(KIND_TOP,                  8'h00, 6'd0,  2'd0);
        add_req(lcdnx_pkg::KIND_DATA,      8'h81, 6'd0,  2'd0);
        drain();

        // Backlight on, four lines: every row offset, widest address sum
        write_reg(lcdnx_pkg::REG_BACKLIGHT, 3'd1);
        write_reg(lcdnx_pkg::REG_LINE_COUNT, 3'd4);
        add_req(lcdnx_pkg::KIND_CURSOR,    8'h00, 6'd0,  2'd0);
        add_req(lcdnx_pkg::KIND_CURSOR,    8'h00, 6'd7,  2'd1);
        add_req(lcdnx_pkg::KIND_CURSOR,    8'h00, 6'd19, 2'd2);
        add_req(lcdnx_pkg::KIND_CURSOR,    8'h00, 6'd63, 2'd3);
        add_req(lcdnx_pkg::KIND_BACKLIGHT, 8'h00, 6'd0,  2'd0);
        add_req(lcdnx_pkg::KIND_DATA,      8'h00, 6'd0,  2'd0);
        add_random(60);
        drain();

        // Line count zero counts as one; no idling anywhere
        write_reg(lcdnx_pkg::REG_BACKLIGHT, 3'd0);
        write_reg(lcdnx_pkg::REG_LINE_COUNT, 3'd0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        add_random(50);
        drain();

        // Line count above four; output held off while requests keep coming
        write_reg(lcdnx_pkg::REG_BACKLIGHT, 3'd1);
        write_reg(lcdnx_pkg::REG_LINE_COUNT, 3'd7);
        pressure_phase = 1'b1;
        add_random(50);
        drain();
        pressure_phase = 1'b0;

        // Line counts one, three and five; random idling on both sides, none on the request side for five
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        write_reg(lcdnx_pkg::REG_LINE_COUNT, 3'd1);
        add_random(35);
        drain();
        write_reg(lcdnx_pkg::REG_BACKLIGHT, 3'd0);
        write_reg(lcdnx_pkg::REG_LINE_COUNT, 3'd3);
        add_random(35);
        drain();
        write_reg(lcdnx_pkg::REG_LINE_COUNT, 3'd5);
        tx_idle_on = 1'b0;
        add_random(30);
        drain();

        if (mismatches == 0 && bytes_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> lcd_nibble_expander_writer_top.f
+incdir+rtl/core
rtl/core/lcdnx_pkg.sv
rtl/core/lcdnx_req_decode.sv
rtl/core/lcd_nibble_expander_writer_top.sv
tb/lcd_nibble_expander_writer_top_tb.sv
